// ===== hw/rtl/histeq_pkg.sv =====
package histeq_pkg;

    localparam int BINS       = 256;
    localparam int BIN_AW     = $clog2(BINS);
    localparam int GREY_W     = 8;
    localparam int COUNT_W    = 25;
    localparam int DIM_W      = 13;
    localparam int TOTAL_W    = 25;
    localparam int THR_W      = 33;
    localparam int ACC_W      = 41;
    localparam int CMD_W      = 2;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [GREY_W-1:0]  GREY_MAX  = 8'd255;
    localparam logic [DIM_W-1:0]   DIM_MAX   = 13'd4096;
    localparam logic [DIM_W-1:0]   DIM_RESET = 13'd256;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h1FF_FFFF;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_MAP   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CNT,
        ST_TOTAL,
        ST_ACC,
        ST_STEP,
        ST_MAP,
        ST_OUT
    } state_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = {{(DIM_W-1){1'b0}}, 1'b1};
        else if (v > DIM_MAX)
            r = DIM_MAX;
        else
            r = v;
        return r;
    endfunction

endpackage

// ===== hw/rtl/histogram_equalizer.sv =====
// Flow from the accepting beat: a clear resets the histogram valid bits, a count writes its
// bin back in ST_CNT, and a map with a built table goes through ST_OUT to m_tvalid. A map that
// finds the table stale first builds it: ST_TOTAL, then ST_ACC and ST_STEP for each of the 256
// bins (at most 255 table steps in all), then ST_MAP; the build loop makes a single cumulative compare per cycle.
// Throughput: one item in flight; ST_OUT holds while the output is full and m_tready is low.
// Reset: histogram valid bits, table-ready flag, state and output valid clear at once;
// width and height return to 256. No clearing pass; the table memory holds no reset value.
module histogram_equalizer
(
    input  logic                                clk,
    input  logic                                rst_n,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [histeq_pkg::APB_AW-1:0]       paddr,
    input  logic [histeq_pkg::APB_DW-1:0]       pwdata,
    output logic [histeq_pkg::APB_DW-1:0]       prdata,
    output logic                                pready,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] pixel
    input  logic [histeq_pkg::CMD_W-1:0]        s_tuser,   // [1:0] cmd
    // output stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata    // [7:0] out_pixel
);
    import histeq_pkg::*;

    // configuration
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             cfg_wr;

    // control
    state_t state_reg, state_next;
    logic   table_ready_reg, table_ready_next;
    logic   out_valid_reg, out_valid_next;
    logic [GREY_W-1:0] out_data_reg, out_data_next;

    // datapath
    logic [BIN_AW-1:0]  pix_reg, pix_next;
    logic [BIN_AW-1:0]  g_reg, g_next;
    logic [GREY_W-1:0]  q_reg, q_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // memories
    logic [COUNT_W-1:0] bin_mem [BINS];
    logic [BINS-1:0]    bin_vld_reg;
    logic [COUNT_W-1:0] bin_q;
    logic               bin_q_vld;
    logic [GREY_W-1:0]  tbl_mem [BINS];
    logic [GREY_W-1:0]  tbl_q;

    logic [BIN_AW-1:0]  bin_raddr;
    logic [BIN_AW-1:0]  tbl_raddr;
    logic               bin_wr;
    logic               tbl_wr;
    logic               bins_clear;
    logic               in_beat;
    logic               out_free;

    logic [COUNT_W-1:0] bin_val;
    logic [COUNT_W-1:0] bin_inc;
    logic [ACC_W-1:0]   bin_scaled;
    logic [2*DIM_W-1:0] dim_prod;
    logic               step_go;
    cmd_t               in_cmd;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    assign bin_val    = bin_q_vld ? bin_q : '0;
    assign bin_inc    = (bin_val == COUNT_MAX) ? bin_val : bin_val + 1'b1;
    // 255 * bin as (bin << 8) - bin
    assign bin_scaled = ACC_W'({bin_val, 8'd0}) - ACC_W'(bin_val);
    assign dim_prod   = (2*DIM_W)'(clamp_dim(width_reg)) * (2*DIM_W)'(clamp_dim(height_reg));
    assign step_go    = (q_reg != GREY_MAX) && (acc_reg >= ACC_W'(thr_reg));

    // ------------------------------------------------------------------ APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (in_cmd)
                        CMD_COUNT: state_next = ST_CNT;
                        CMD_MAP:   state_next = table_ready_reg ? ST_OUT : ST_TOTAL;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CNT:   state_next = ST_IDLE;
            ST_TOTAL: state_next = ST_ACC;
            ST_ACC:   state_next = ST_STEP;
            ST_STEP:
            begin
                if (!step_go)
                    state_next = (g_reg == BIN_AW'(BINS-1)) ? ST_MAP : ST_ACC;
            end
            ST_MAP:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // -------------------------------------------------------------- outputs
    always_comb
    begin
        s_tready   = 1'b0;
        bin_wr     = 1'b0;
        tbl_wr     = 1'b0;
        bins_clear = 1'b0;
        bin_raddr  = g_next;
        tbl_raddr  = pix_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                bin_raddr  = s_tdata;
                tbl_raddr  = s_tdata;
                bins_clear = in_beat && (in_cmd == CMD_CLEAR);
            end
            ST_CNT:  bin_wr = 1'b1;
            ST_STEP: tbl_wr = !step_go;
            default: ;
        endcase
    end

    // -------------------------------------------------------- datapath next
    always_comb
    begin
        table_ready_next = table_ready_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        pix_next         = pix_reg;
        g_next           = g_reg;
        q_next           = q_reg;
        acc_next         = acc_reg;
        thr_next         = thr_reg;
        total_next       = total_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    pix_next = s_tdata;
                    g_next   = '0;
                    if (in_cmd inside {CMD_CLEAR, CMD_COUNT})
                        table_ready_next = 1'b0;
                end
            end
            ST_TOTAL:
            begin
                total_next = dim_prod[TOTAL_W-1:0];
                thr_next   = THR_W'(dim_prod);
                q_next     = '0;
                acc_next   = '0;
            end
            ST_ACC:
                acc_next = acc_reg + bin_scaled;
            ST_STEP:
            begin
                if (step_go)
                begin
                    // advance the level until the threshold passes the cumulative sum
                    q_next   = q_reg + 1'b1;
                    thr_next = thr_reg + THR_W'(total_reg);
                end
                else
                begin
                    g_next = g_reg + 1'b1;
                    if (g_reg == BIN_AW'(BINS-1))
                        table_ready_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = tbl_q;
                end
            end
            default: ;
        endcase
    end

    // -------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            table_ready_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            bin_vld_reg     <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            table_ready_reg <= table_ready_next;
            out_valid_reg   <= out_valid_next;
            if (bins_clear)
                bin_vld_reg <= '0;
            else if (bin_wr)
                bin_vld_reg[pix_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pix_reg      <= pix_next;
        g_reg        <= g_next;
        q_reg        <= q_next;
        acc_reg      <= acc_next;
        thr_reg      <= thr_next;
        total_reg    <= total_next;
    end

    // histogram memory: read every cycle, write back on count
    always_ff @(posedge clk)
    begin
        if (bin_wr)
            bin_mem[pix_reg] <= bin_inc;
        bin_q     <= bin_mem[bin_raddr];
        bin_q_vld <= bin_vld_reg[bin_raddr] && !bins_clear;
    end

    // mapping table memory
    always_ff @(posedge clk)
    begin
        if (tbl_wr)
            tbl_mem[g_reg] <= q_reg;
        tbl_q <= tbl_mem[tbl_raddr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ------------------------------------------------------------ assertions
    a_sat_stops_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP && q_reg == GREY_MAX) |=> (state_reg != ST_STEP))
        else $error("table step continued past the top grey level");

    a_ready_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(table_ready_reg) |-> ($past(state_reg) == ST_STEP
                                    && $past(g_reg) == BIN_AW'(BINS-1)))
        else $error("table marked ready without a full build sweep");

    a_count_stales_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CNT) |-> !table_ready_reg)
        else $error("count in progress while table marked ready");

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the table lookup");

    a_lookup_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) |-> table_ready_reg)
        else $error("table lookup with stale table");

endmodule

// ===== tb/histogram_equalizer_tb.sv =====
`timescale 1ns / 100ps

module histogram_equalizer_tb;

    localparam int LIMIT_CYCLES  = 6_000_000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        histeq_pkg::cmd_t cmd;
        logic [7:0]       pixel;
    } pix_beat_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [histeq_pkg::APB_AW-1:0] paddr  = '0;
    logic [histeq_pkg::APB_DW-1:0] pwdata = '0;
    logic [histeq_pkg::APB_DW-1:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] pixel
    logic [histeq_pkg::CMD_W-1:0] s_tuser = '0;    // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_pixel

    // predictor state
    logic [histeq_pkg::COUNT_W-1:0] hist_bins [histeq_pkg::BINS] = '{default: '0};
    logic [7:0]  eq_table [histeq_pkg::BINS];
    logic        eq_table_valid = 1'b0;
    logic [histeq_pkg::DIM_W-1:0] cfg_width  = histeq_pkg::DIM_RESET;
    logic [histeq_pkg::DIM_W-1:0] cfg_height = histeq_pkg::DIM_RESET;
    logic [7:0]  want_pixels [$];

    pix_beat_t   pending_beats [$];
    pix_beat_t   next_beat;
    logic        beat_took = 1'b0;
    int          send_gap = 0;
    int          stall_left = 0;
    bit          idle_on = 1'b0;

    int          cycle_count = 0;
    int          fail_count = 0;
    int          beats_sent = 0;
    int          beats_taken = 0;
    int          items_queued = 0;
    int          n_counted = 0;
    int          n_mapped = 0;
    int          n_cleared = 0;
    int          n_unused = 0;
    int          n_builds = 0;
    int          n_settings = 0;

    histogram_equalizer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("histogram_equalizer_tb failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (fail_count < 20)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    function automatic logic [63:0] clamp_size(input logic [histeq_pkg::DIM_W-1:0] v);
        if (v == '0)
            return 64'd1;
        if (v > histeq_pkg::DIM_MAX)
            return 64'(histeq_pkg::DIM_MAX);
        return 64'(v);
    endfunction

    function automatic void build_eq_table();
        logic [63:0] total;
        logic [63:0] cum;
        logic [63:0] q;
        total = clamp_size(cfg_width) * clamp_size(cfg_height);
        cum = '0;
        for (int g = 0; g < histeq_pkg::BINS; g++)
        begin
            cum = cum + 64'(hist_bins[g]);
            q = (64'(histeq_pkg::GREY_MAX) * cum) / total;
            eq_table[g] = (q > 64'(histeq_pkg::GREY_MAX)) ? histeq_pkg::GREY_MAX : q[7:0];
        end
        eq_table_valid = 1'b1;
        n_builds++;
    endfunction

    function automatic void eq_apply(input histeq_pkg::cmd_t c, input logic [7:0] p);
        case (c)
            histeq_pkg::CMD_CLEAR:
            begin
                foreach (hist_bins[i])
                    hist_bins[i] = '0;
                eq_table_valid = 1'b0;
                n_cleared++;
            end
            histeq_pkg::CMD_COUNT:
            begin
                if (hist_bins[p] != histeq_pkg::COUNT_MAX)
                    hist_bins[p] = hist_bins[p] + 1'b1;
                eq_table_valid = 1'b0;
                n_counted++;
            end
            histeq_pkg::CMD_MAP:
            begin
                if (!eq_table_valid)
                    build_eq_table();
                want_pixels.push_back(eq_table[p]);
                n_mapped++;
            end
            default:
                n_unused++;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // sender: hold the beat until taken, then advance after an optional gap
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || beat_took)
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                next_beat = pending_beats.pop_front();
                beats_sent++;
                s_tvalid <= 1'b1;
                s_tuser  <= next_beat.cmd;
                s_tdata  <= next_beat.pixel;
                send_gap <= pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 99) < 15)
        begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        logic [7:0] want;
        if (!rst_n)
        begin
            beat_took <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (want_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("out_pixel %0d with no map pending", m_tdata));
                end
                else
                begin
                    want = want_pixels.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("out_pixel %0d, expected %0d",
                                                  m_tdata, want));
                end
            end
            beat_took <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
            begin
                eq_apply(histeq_pkg::cmd_t'(s_tuser), s_tdata);
                beats_taken++;
            end
        end
    end

    task automatic push_beat(input histeq_pkg::cmd_t c, input logic [7:0] p);
        pix_beat_t b;
        b.cmd = c;
        b.pixel = p;
        pending_beats.push_back(b);
        if (c != histeq_pkg::CMD_NONE)
            items_queued++;
    endtask

    task automatic reg_access(input bit wr, input histeq_pkg::reg_idx_t idx,
                              input logic [histeq_pkg::DIM_W-1:0] v);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = wr ? 32'(v) : '0;
        @(negedge clk);
        penable = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (wr)
        begin
            if (idx == histeq_pkg::REG_WIDTH)
                cfg_width = v;
            else
                cfg_height = v;
        end
        else if (prdata !== 32'(v))
        begin
            report_mismatch($sformatf("register %s reads %0d, expected %0d",
                                      idx.name(), prdata, v));
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // block until every queued beat is taken and every map answered
    task automatic wait_idle();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_beats.size() != 0 || beats_taken != beats_sent ||
               want_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one image: a clear (mostly), a run of counts around a random grey band, then maps; or a short run of random beats
    task automatic add_frame();
        int kind;
        int n;
        int base;
        int spread;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            n = $urandom_range(4, 24);
            for (int k = 0; k < n; k++)
                push_beat(histeq_pkg::cmd_t'($urandom_range(0, 3)), 8'($urandom));
        end
        else
        begin
            if (kind < 90)
                push_beat(histeq_pkg::CMD_CLEAR, 8'($urandom));
            base = $urandom_range(0, 255);
            spread = $urandom_range(0, 255);
            n = $urandom_range(1, 48);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    push_beat(histeq_pkg::CMD_NONE, 8'($urandom));
                push_beat(histeq_pkg::CMD_COUNT, 8'(base + $urandom_range(0, spread)));
            end
            n = $urandom_range(1, 32);
            for (int k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                // stray counts and clears force a rebuild mid-pass
                if (r < 4)
                    push_beat(histeq_pkg::CMD_COUNT, 8'($urandom));
                else if (r < 6)
                    push_beat(histeq_pkg::CMD_CLEAR, 8'($urandom));
                else if (r < 9)
                    push_beat(histeq_pkg::CMD_NONE, 8'($urandom));
                if (r[0])
                    push_beat(histeq_pkg::CMD_MAP, 8'($urandom));
                else
                    push_beat(histeq_pkg::CMD_MAP, 8'(base + $urandom_range(0, spread)));
            end
        end
    endtask

    task automatic run_phase(input logic [histeq_pkg::DIM_W-1:0] w,
                             input logic [histeq_pkg::DIM_W-1:0] h, input int n_items);
        int target;
        wait_idle();
        reg_access(1'b1, histeq_pkg::REG_WIDTH, w);
        reg_access(1'b1, histeq_pkg::REG_HEIGHT, h);
        reg_access(1'b0, histeq_pkg::REG_WIDTH, w);
        reg_access(1'b0, histeq_pkg::REG_HEIGHT, h);
        n_settings++;
        idle_on = ($urandom_range(0, 3) != 0);
        target = items_queued + n_items;
        while (items_queued < target)
            add_frame();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        reg_access(1'b0, histeq_pkg::REG_WIDTH, histeq_pkg::DIM_RESET);
        reg_access(1'b0, histeq_pkg::REG_HEIGHT, histeq_pkg::DIM_RESET);
        n_settings++;

        // empty histogram maps to zero; unused command changes nothing
        push_beat(histeq_pkg::CMD_MAP, 8'd0);
        push_beat(histeq_pkg::CMD_MAP, 8'd255);
        push_beat(histeq_pkg::CMD_NONE, 8'd255);
        push_beat(histeq_pkg::CMD_COUNT, 8'd0);
        push_beat(histeq_pkg::CMD_COUNT, 8'd255);
        push_beat(histeq_pkg::CMD_COUNT, 8'd128);
        push_beat(histeq_pkg::CMD_COUNT, 8'd128);
        push_beat(histeq_pkg::CMD_MAP, 8'd128);
        push_beat(histeq_pkg::CMD_NONE, 8'd0);
        wait_idle();

        // a size change alone keeps the old table; the next count forces a
        // rebuild, and five pixels on a 2x2 image saturate the top entry
        reg_access(1'b1, histeq_pkg::REG_WIDTH, 13'd2);
        reg_access(1'b1, histeq_pkg::REG_HEIGHT, 13'd2);
        n_settings++;
        idle_on = 1'b1;
        push_beat(histeq_pkg::CMD_MAP, 8'd255);
        push_beat(histeq_pkg::CMD_MAP, 8'd0);
        push_beat(histeq_pkg::CMD_COUNT, 8'd255);
        push_beat(histeq_pkg::CMD_MAP, 8'd0);
        push_beat(histeq_pkg::CMD_MAP, 8'd128);
        push_beat(histeq_pkg::CMD_MAP, 8'd255);
        push_beat(histeq_pkg::CMD_CLEAR, 8'd0);
        push_beat(histeq_pkg::CMD_MAP, 8'd7);
        push_beat(histeq_pkg::CMD_COUNT, 8'd3);
        push_beat(histeq_pkg::CMD_COUNT, 8'd3);
        push_beat(histeq_pkg::CMD_NONE, 8'd3);
        push_beat(histeq_pkg::CMD_MAP, 8'd3);
        push_beat(histeq_pkg::CMD_MAP, 8'd2);

        run_phase(13'd4, 13'd4, 160);
        run_phase(13'd1, 13'd1, 160);
        run_phase(13'd0, 13'd0, 160);
        run_phase(13'd8191, 13'd8191, 160);
        run_phase(13'd4096, 13'd4096, 160);
        run_phase(13'd4096, 13'd1, 160);
        run_phase(13'd1, 13'd4096, 160);
        run_phase(13'($urandom_range(1, 12)), 13'($urandom_range(1, 12)), 160);
        run_phase(13'($urandom_range(1, 24)), 13'($urandom_range(1, 6)), 160);
        run_phase(13'($urandom), 13'($urandom), 160);
        wait_idle();

        $display("covered %0d beats over %0d size settings: %0d counts, %0d maps, %0d clears, %0d unused",
                 beats_taken, n_settings, n_counted, n_mapped, n_cleared, n_unused);
        $display("table rebuilt %0d times, %0d mismatches", n_builds, fail_count);
        if (fail_count == 0)
            $display("histogram_equalizer_tb passed");
        else
            $display("histogram_equalizer_tb failed");
        $finish;
    end

endmodule
